>>> hdl/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 42;
  localparam int unsigned CountW  = 4;
  localparam int unsigned RemW    = 3;
  localparam int unsigned ContW   = 6;
  localparam int unsigned LeadW   = 4;

  localparam logic [ContW-1:0] ContMask = 6'h3f;

  typedef struct packed {
    logic [RemW-1:0]   rem;
    logic [CodeW-1:0]  acc;
    logic [CountW-1:0] len;
  } dec_state_t;

  typedef struct packed {
    logic              valid;
    logic [CodeW-1:0]  code;
    logic [CountW-1:0] count;
    logic              trunc;
  } dec_result_t;

endpackage

>>> hdl/utf8sd_step.sv
// Next-state and result logic for one input byte.
module utf8sd_step
  import utf8sd_pkg::*;
(
  input  dec_state_t        state_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              last_i,
  output dec_state_t        state_o,
  output dec_result_t       result_o
);

  logic [LeadW-1:0]  lead_n;
  logic              run;
  logic [ByteW-1:0]  low_bits;
  logic [CodeW-1:0]  acc_shift;
  logic [RemW-1:0]   rem_dec;

  always_comb begin
    lead_n = '0;
    run    = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      if (run && data_byte_i[i]) begin
        lead_n = lead_n + LeadW'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  assign low_bits  = data_byte_i & (8'hff >> lead_n);
  assign acc_shift = {state_i.acc[CodeW-ContW-1:0], data_byte_i[ContW-1:0] & ContMask};
  assign rem_dec   = state_i.rem - RemW'(1);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.rem == '0) begin
      if (lead_n == LeadW'(0) || lead_n == LeadW'(1)) begin
        result_o.valid = 1'b1;
        result_o.code  = CodeW'(low_bits);
        result_o.count = CountW'(1);
      end else if (last_i) begin
        result_o.valid = 1'b1;
        result_o.count = CountW'(1);
        result_o.trunc = 1'b1;
      end else begin
        state_o.acc = CodeW'(low_bits);
        state_o.rem = RemW'(lead_n - LeadW'(1));
        state_o.len = CountW'(lead_n);
      end
    end else begin
      state_o.acc = acc_shift;
      state_o.rem = rem_dec;
      if (rem_dec == '0) begin
        result_o.valid = 1'b1;
        result_o.code  = acc_shift;
        result_o.count = state_i.len;
        state_o        = '0;
      end else if (last_i) begin
        result_o.valid = 1'b1;
        result_o.count = state_i.len - {1'b0, rem_dec};
        result_o.trunc = 1'b1;
        state_o        = '0;
      end
    end
  end

endmodule

>>> hdl/utf8_stream_decoder.sv
// Top level: lenient UTF-8 byte stream decoder with registered result.
// The result is registered: it appears on the output register in the cycle after its last byte is accepted.
// Throughput: one byte per cycle while in_stall_o is low; the single result register takes a new item
// in the cycle its current one is taken.
// Reset: clears the pending sequence state and the output valid flag.
module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              end_of_buffer_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CodeW-1:0]  code_point_o,
  output logic [CountW-1:0] byte_count_o,
  output logic              truncated_o
);

  dec_state_t        state_q, state_d;
  dec_result_t       res_d;
  logic              out_valid_q;
  logic [CodeW-1:0]  code_q;
  logic [CountW-1:0] count_q;
  logic              trunc_q;
  logic              accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  utf8sd_step u_step (
    .state_i     (state_q),
    .data_byte_i (data_byte_i),
    .last_i      (end_of_buffer_i),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= res_d.valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_d.valid) begin
      code_q  <= res_d.code;
      count_q <= res_d.count;
      trunc_q <= res_d.trunc;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = code_q;
  assign byte_count_o = count_q;
  assign truncated_o  = trunc_q;

`ifndef SYNTHESIS
  a_trunc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> code_point_o == '0)
    else $error("truncated item carries a non-zero code");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o != '0 && byte_count_o <= CountW'(8))
    else $error("byte count out of range");

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.rem != '0 |-> state_q.len >= CountW'(2) && {1'b0, state_q.rem} < state_q.len)
    else $error("pending sequence length inconsistent");

  a_trunc_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_d.valid |=> state_q.rem == '0)
    else $error("state still pending after a result");
`endif

endmodule
